[sv/tsim_pkg.sv]
package tsim_pkg;

  localparam int DATA_W    = 32;
  localparam int DIM_SLOTS = 4;
  localparam int SLOT_W    = 2;
  localparam int ADDR_W    = 5;
  // radix-2 restoring steps, then multiply, then accumulate
  localparam int DIV_STEPS  = DATA_W;
  localparam int DIM_STAGES = DIV_STEPS + 2;

  // register map, word index = paddr[4:2]
  localparam logic [2:0] REG_IN_STRIDE_0  = 3'd0;
  localparam logic [2:0] REG_OUT_STRIDE_0 = 3'd4;

  typedef logic [DATA_W-1:0] word_t;

endpackage

[sv/transpose_source_index_mapper.sv]
// Maps a linear block index of a transposed output tensor to the block index
// in the input tensor, for an address generator feeding a transpose copy.
// Input channel: out_index with in_valid/in_ready. Output channel: src_index
// with out_valid/out_ready. Strides are set over the APB port: word 0..3 are
// in_stride_0..3, word 4..7 are out_stride_0..3, outermost first; write them
// only while no beat is in flight. An unused leading dimension takes out
// stride 0xFFFFFFFF.
// Each dimension is a 34-stage pipeline: 32 restoring divide steps, one
// multiply stage, one accumulate stage. A beat passes through the MAX_RANK
// dimensions in order, and one beat is accepted every cycle while the output
// is not stalled.
// The whole pipeline advances together: when out_valid is high and the
// receiver holds out_ready low, in_ready drops and every stage holds, so
// nothing is lost or repeated. Bubbles travel through as invalid stages.
// Reset clears all stage valid bits and sets every stride register to one.
module transpose_source_index_mapper
  import tsim_pkg::*;
#(
  parameter int MAX_RANK = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       out_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       src_index,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  word_t in_stride  [DIM_SLOTS];
  word_t out_stride [DIM_SLOTS];

  logic [2:0] reg_idx;
  logic       wr_en;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIM_SLOTS; k++) begin
        in_stride[k]  <= word_t'(1);
        out_stride[k] <= word_t'(1);
      end
    end else if (wr_en) begin
      if (reg_idx >= REG_OUT_STRIDE_0) begin
        out_stride[reg_idx[SLOT_W-1:0]] <= pwdata;
      end else begin
        in_stride[reg_idx[SLOT_W-1:0]] <= pwdata;
      end
    end
  end

  assign prdata = (reg_idx >= REG_OUT_STRIDE_0) ? out_stride[reg_idx[SLOT_W-1:0]]
                                                : in_stride[reg_idx[SLOT_W-1:0]];

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic  ch_vld [MAX_RANK+1];
  word_t ch_rem [MAX_RANK+1];
  word_t ch_acc [MAX_RANK+1];

  assign ch_vld[0] = in_valid;
  assign ch_rem[0] = out_index;
  assign ch_acc[0] = '0;

  genvar d;
  generate
    for (d = 0; d < MAX_RANK; d++) begin : g_dim
      tsim_dim u_dim (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .in_vld  (ch_vld[d]),
        .in_rem  (ch_rem[d]),
        .in_acc  (ch_acc[d]),
        .div     (out_stride[d]),
        .mul     (in_stride[d]),
        .out_vld (ch_vld[d+1]),
        .out_rem (ch_rem[d+1]),
        .out_acc (ch_acc[d+1])
      );
    end
  endgenerate

  assign out_valid = ch_vld[MAX_RANK];
  assign src_index = ch_acc[MAX_RANK];

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

[sv/tsim_dim.sv]
module tsim_dim
  import tsim_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_vld,
  input  word_t in_rem,
  input  word_t in_acc,
  input  word_t div,
  input  word_t mul,
  output logic  out_vld,
  output word_t out_rem,
  output word_t out_acc
);

  logic  vld [DIV_STEPS+1];
  word_t rm  [DIV_STEPS+1];
  word_t nm  [DIV_STEPS+1];
  word_t qt  [DIV_STEPS+1];
  word_t ac  [DIV_STEPS+1];

  assign vld[0] = in_vld;
  assign rm[0]  = '0;
  assign nm[0]  = in_rem;
  assign qt[0]  = '0;
  assign ac[0]  = in_acc;

  genvar i;
  generate
    for (i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [DATA_W:0] trial;
      logic            ge;
      assign trial = {rm[i], nm[i][DATA_W-1]};
      assign ge    = trial >= {1'b0, div};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i+1] <= 1'b0;
        end else if (adv) begin
          vld[i+1] <= vld[i];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rm[i+1] <= ge ? DATA_W'(trial - {1'b0, div}) : trial[DATA_W-1:0];
          nm[i+1] <= {nm[i][DATA_W-2:0], 1'b0};
          qt[i+1] <= {qt[i][DATA_W-2:0], ge};
          ac[i+1] <= ac[i];
        end
      end
    end
  endgenerate

  // a zero stride divides to all ones with the dividend left as remainder; q_eff forces that quotient to zero
  word_t             q_eff;
  logic [2*DATA_W-1:0] prod_full;
  assign q_eff     = (div == '0) ? '0 : qt[DIV_STEPS];
  assign prod_full = q_eff * mul;

  logic  m_vld;
  word_t m_rem;
  word_t m_acc;
  word_t m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      m_vld   <= vld[DIV_STEPS];
      out_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_rem   <= rm[DIV_STEPS];
      m_acc   <= ac[DIV_STEPS];
      m_prod  <= prod_full[DATA_W-1:0];
      out_rem <= m_rem;
      out_acc <= m_acc + m_prod;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS] && div != '0 |-> rm[DIV_STEPS] < div)
    else $error("remainder not below stride");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(out_vld) && $stable(m_vld))
    else $error("pipeline moved while stalled");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[1] == $past(vld[0]))
    else $error("valid lost at pipeline entry");

endmodule
